// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the segment distance core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define SSD_ASSERT_DELAY(name, clk, rst_n, ante, dly, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Widths, constants and request/result types of the segment distance core.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int DIST_BITS  = 25;
    localparam int RAD_BITS   = 2 * DIST_BITS;
    localparam int DIST_SHIFT = 2 * FRAC_BITS;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int DOT_BITS   = 2 * DIFF_BITS + 2;
    localparam int PROD_BITS  = 2 * DOT_BITS;
    localparam int DET_BITS   = PROD_BITS + 1;

    localparam int P_BITS     = DIFF_BITS + FRAC_BITS + 3;
    localparam int SQ_BITS    = 2 * P_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int Y_BITS     = SUM_BITS - DIST_SHIFT;
    localparam int Y_EXT      = (Y_BITS > RAD_BITS) ? Y_BITS : RAD_BITS + 1;

    localparam int DIV_LAT    = FRAC_BITS + 1;
    localparam int SQRT_LAT   = DIST_BITS;
    localparam int FRONT_LAT  = 8;
    localparam int BACK_LAT   = 5;
    localparam int UVW_DLY    = FRONT_LAT - 1 + DIV_LAT;
    localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT + SQRT_LAT + 1;

    localparam logic [FRAC_BITS:0]   ONE_Q16  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] s_start_x;
        logic signed [COORD_BITS-1:0] s_start_y;
        logic signed [COORD_BITS-1:0] s_start_z;
        logic signed [COORD_BITS-1:0] s_end_x;
        logic signed [COORD_BITS-1:0] s_end_y;
        logic signed [COORD_BITS-1:0] s_end_z;
        logic signed [COORD_BITS-1:0] k_start_x;
        logic signed [COORD_BITS-1:0] k_start_y;
        logic signed [COORD_BITS-1:0] k_start_z;
        logic signed [COORD_BITS-1:0] k_end_x;
        logic signed [COORD_BITS-1:0] k_end_y;
        logic signed [COORD_BITS-1:0] k_end_z;
    } ssd_req_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] closest_distance;
        logic [FRAC_BITS:0]   param_on_s;
        logic [FRAC_BITS:0]   param_on_k;
    } ssd_result_t;

endpackage

// ===== rtl/ssd_div.sv =====
// ----------------------------------------------------------------------------
// ssd_div
// Pipelined fraction unit: floor(num * 2^16 / den), clamped to [0, 1].
// ----------------------------------------------------------------------------
module ssd_div
    import ssd_pkg::*;
#(
    parameter int NUM_BITS = DET_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic signed [NUM_BITS-1:0] den,
    output logic                       out_valid,
    output logic [FRAC_BITS:0]         quot
);

    localparam int MAG = NUM_BITS - 1;
    localparam int REM = NUM_BITS;

    logic                 vld_reg  [0:FRAC_BITS];
    logic                 zero_reg [0:FRAC_BITS];
    logic                 one_reg  [0:FRAC_BITS];
    logic [REM-1:0]       rem_reg  [0:FRAC_BITS];
    logic [MAG-1:0]       den_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg    [0:FRAC_BITS];

    logic zero_next;
    logic one_next;

    always_comb
    begin
        zero_next = num[NUM_BITS-1] || (num == '0) || den[NUM_BITS-1] || (den == '0);
        one_next  = !zero_next && !(num < den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= zero_next;
        one_reg[0]  <= one_next;
        rem_reg[0]  <= {1'b0, num[MAG-1:0]};
        den_reg[0]  <= den[MAG-1:0];
        q_reg[0]    <= '0;
    end

    for (genvar j = 1; j <= FRAC_BITS; j++)
    begin : g_step
        logic [REM-1:0] shifted;
        logic           ge;

        always_comb
        begin
            shifted = {rem_reg[j-1][REM-2:0], 1'b0};
            ge      = shifted >= {1'b0, den_reg[j-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[j] <= zero_reg[j-1];
            one_reg[j]  <= one_reg[j-1];
            den_reg[j]  <= den_reg[j-1];
            rem_reg[j]  <= ge ? (shifted - {1'b0, den_reg[j-1]}) : shifted;
            q_reg[j]    <= {q_reg[j-1][FRAC_BITS-2:0], ge};
        end
    end

    assign out_valid = vld_reg[FRAC_BITS];
    assign quot      = one_reg[FRAC_BITS]  ? ONE_Q16 :
                       zero_reg[FRAC_BITS] ? '0 : {1'b0, q_reg[FRAC_BITS]};

endmodule

// ===== rtl/ssd_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssd_sqrt
// Pipelined integer square root, one root bit per stage, saturating.
// ----------------------------------------------------------------------------
module ssd_sqrt
    import ssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 sat,
    input  logic [RAD_BITS-1:0]  rad,
    output logic                 out_valid,
    output logic [DIST_BITS-1:0] root
);

    logic                 vld_reg  [0:SQRT_LAT-1];
    logic                 sat_reg  [0:SQRT_LAT-1];
    logic [RAD_BITS-1:0]  rad_reg  [0:SQRT_LAT-1];
    logic [DIST_BITS-1:0] root_reg [0:SQRT_LAT-1];

    for (genvar j = 0; j < SQRT_LAT; j++)
    begin : g_step
        logic                 vld_in;
        logic                 sat_in;
        logic [RAD_BITS-1:0]  rad_in;
        logic [DIST_BITS-1:0] root_in;
        logic [DIST_BITS-1:0] cand;
        logic [RAD_BITS-1:0]  cand_sq;

        if (j == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign sat_in  = sat;
            assign rad_in  = rad;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign sat_in  = sat_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        always_comb
        begin
            cand    = root_in | (DIST_BITS'(1) << (DIST_BITS - 1 - j));
            cand_sq = RAD_BITS'(cand) * RAD_BITS'(cand);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sat_reg[j]  <= sat_in;
            rad_reg[j]  <= rad_in;
            root_reg[j] <= (cand_sq <= rad_in) ? cand : root_in;
        end
    end

    assign out_valid = vld_reg[SQRT_LAT-1];
    assign root      = sat_reg[SQRT_LAT-1] ? DIST_MAX : root_reg[SQRT_LAT-1];

endmodule

// ===== rtl/segment_segment_distance_core.sv =====
// ----------------------------------------------------------------------------
// segment_segment_distance_core
// Closest distance between two 3D segments and the closest-point parameters.
//
// A request (two segment endpoint pairs, signed Q16.8) is taken at every
// rising edge where start is high and busy is low; busy stays low, so a new
// request may be issued every cycle.
// The result (distance as unsigned Q17.8, both parameters as Q1.16) shows
// on result for one cycle with done high. One request per cycle, results in order.
// Latency comes from 8 front stages (differences, dot products, split wide
// products, determinant, edge clamping), a 17-stage fraction unit (a setup
// stage, then one quotient bit per stage), 5 stages of distance arithmetic,
// a 25-stage root unit (one bit per stage) and the output register.
// Reset clears the valid bits of every stage; requests in flight are lost.
// The receiver cannot stall: each result must be taken the cycle it shows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_segment_distance_core
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ssd_req_t    req,
    output logic        done,
    output ssd_result_t result
);

    localparam int HB = DOT_BITS / 2;
    localparam int PH = P_BITS / 2;
    localparam int PU = P_BITS - PH;

    logic signed [COORD_BITS-1:0] ss [3];
    logic signed [COORD_BITS-1:0] se [3];
    logic signed [COORD_BITS-1:0] ks [3];
    logic signed [COORD_BITS-1:0] ke [3];

    logic [FRONT_LAT-1:0] front_vld_reg;
    logic [BACK_LAT-1:0]  back_vld_reg;

    // differences
    logic signed [DIFF_BITS-1:0] u_reg [3];
    logic signed [DIFF_BITS-1:0] v_reg [3];
    logic signed [DIFF_BITS-1:0] w_reg [3];

    // dot product terms
    logic signed [2*DIFF_BITS-1:0] uu_reg [3];
    logic signed [2*DIFF_BITS-1:0] uv_reg [3];
    logic signed [2*DIFF_BITS-1:0] vv_reg [3];
    logic signed [2*DIFF_BITS-1:0] uw_reg [3];
    logic signed [2*DIFF_BITS-1:0] vw_reg [3];

    logic signed [DOT_BITS-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    logic signed [DOT_BITS-1:0] a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;
    logic signed [DOT_BITS-1:0] ap_reg, bp_reg, cp_reg, dp_reg, ep_reg;
    logic signed [DOT_BITS-1:0] a5_reg, b5_reg, c5_reg, d5_reg, e5_reg;

    // wide products as half-width partial products
    logic signed [DOT_BITS-1:0]  mx [6];
    logic signed [DOT_BITS-1:0]  my [6];
    logic signed [2*HB-1:0]      phh_reg [6];
    logic signed [2*HB:0]        phl_reg [6];
    logic signed [2*HB:0]        plh_reg [6];
    logic        [2*HB-1:0]      pll_reg [6];
    logic signed [PROD_BITS-1:0] prod_next [6];

    logic signed [PROD_BITS-1:0] ac_reg, bb_reg, be_reg, cd_reg, ae_reg, bd_reg;

    logic signed [DET_BITS-1:0] det_reg, sn0_reg, tn0_reg;

    logic signed [DET_BITS-1:0] sn6_next, sd6_next, tn6_next, td6_next;
    logic signed [DET_BITS-1:0] sn6_reg, sd6_reg, tn6_reg, td6_reg;
    logic signed [DET_BITS-1:0] ndv_reg, bmd_reg, a6_reg;

    logic signed [DET_BITS-1:0] sn7_next, sd7_next, tn7_next, td7_next;
    logic signed [DET_BITS-1:0] sn7_reg, sd7_reg, tn7_reg, td7_reg;

    logic                 div_s_vld, div_t_vld;
    logic [FRAC_BITS:0]   sc_q, tc_q;

    logic signed [DIFF_BITS-1:0] u_dly_reg [UVW_DLY][3];
    logic signed [DIFF_BITS-1:0] v_dly_reg [UVW_DLY][3];
    logic signed [DIFF_BITS-1:0] w_dly_reg [UVW_DLY][3];

    logic signed [P_BITS-1:0]  su_reg [3];
    logic signed [P_BITS-1:0]  tv_reg [3];
    logic signed [P_BITS-1:0]  ws_reg [3];
    logic signed [P_BITS-1:0]  p_reg  [3];
    logic signed [2*PU-1:0]    qhh_reg [3];
    logic signed [PU+PH:0]     qhl_reg [3];
    logic        [2*PH-1:0]    qll_reg [3];
    logic signed [SQ_BITS-1:0] sq_next [3];
    logic signed [SQ_BITS-1:0] sq_reg [3];

    logic [FRAC_BITS:0] sc1_reg, tc1_reg, sc2_reg, tc2_reg, sc3_reg, tc3_reg;
    logic [FRAC_BITS:0] sc4_reg, tc4_reg, sc5_reg, tc5_reg;

    logic [SUM_BITS-1:0]  sum_next;
    logic [Y_EXT-1:0]     y_ext;
    logic                 sat_reg;
    logic [RAD_BITS-1:0]  rad_reg;

    logic                 root_vld;
    logic [DIST_BITS-1:0] root;

    logic [FRAC_BITS:0] sc_dly_reg [SQRT_LAT];
    logic [FRAC_BITS:0] tc_dly_reg [SQRT_LAT];

    logic        done_reg;
    ssd_result_t result_reg;

    assign busy = 1'b0;

    always_comb
    begin
        ss[0] = req.s_start_x;  ss[1] = req.s_start_y;  ss[2] = req.s_start_z;
        se[0] = req.s_end_x;    se[1] = req.s_end_y;    se[2] = req.s_end_z;
        ks[0] = req.k_start_x;  ks[1] = req.k_start_y;  ks[2] = req.k_start_z;
        ke[0] = req.k_end_x;    ke[1] = req.k_end_y;    ke[2] = req.k_end_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            back_vld_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            front_vld_reg <= {front_vld_reg[FRONT_LAT-2:0], start && !busy};
            back_vld_reg  <= {back_vld_reg[BACK_LAT-2:0], div_s_vld && div_t_vld};
            done_reg      <= root_vld;
        end
    end

    // operand pairs of ac, bb, be, cd, ae, bd
    always_comb
    begin
        mx[0] = a3_reg;  my[0] = c3_reg;
        mx[1] = b3_reg;  my[1] = b3_reg;
        mx[2] = b3_reg;  my[2] = e3_reg;
        mx[3] = c3_reg;  my[3] = d3_reg;
        mx[4] = a3_reg;  my[4] = e3_reg;
        mx[5] = b3_reg;  my[5] = d3_reg;
        for (int i = 0; i < 6; i++)
        begin
            prod_next[i] = (PROD_BITS'(phh_reg[i]) <<< (2*HB))
                         + (PROD_BITS'(phl_reg[i]) <<< HB)
                         + (PROD_BITS'(plh_reg[i]) <<< HB)
                         + PROD_BITS'(pll_reg[i]);
        end
    end

    // front stages: differences, dot terms, dot sums, wide products, determinant, clamping
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_reg[i]  <= DIFF_BITS'(se[i]) - DIFF_BITS'(ss[i]);
            v_reg[i]  <= DIFF_BITS'(ke[i]) - DIFF_BITS'(ks[i]);
            w_reg[i]  <= DIFF_BITS'(ss[i]) - DIFF_BITS'(ks[i]);
            uu_reg[i] <= (2*DIFF_BITS)'(u_reg[i]) * (2*DIFF_BITS)'(u_reg[i]);
            uv_reg[i] <= (2*DIFF_BITS)'(u_reg[i]) * (2*DIFF_BITS)'(v_reg[i]);
            vv_reg[i] <= (2*DIFF_BITS)'(v_reg[i]) * (2*DIFF_BITS)'(v_reg[i]);
            uw_reg[i] <= (2*DIFF_BITS)'(u_reg[i]) * (2*DIFF_BITS)'(w_reg[i]);
            vw_reg[i] <= (2*DIFF_BITS)'(v_reg[i]) * (2*DIFF_BITS)'(w_reg[i]);
        end
        a3_reg <= DOT_BITS'(uu_reg[0]) + DOT_BITS'(uu_reg[1]) + DOT_BITS'(uu_reg[2]);
        b3_reg <= DOT_BITS'(uv_reg[0]) + DOT_BITS'(uv_reg[1]) + DOT_BITS'(uv_reg[2]);
        c3_reg <= DOT_BITS'(vv_reg[0]) + DOT_BITS'(vv_reg[1]) + DOT_BITS'(vv_reg[2]);
        d3_reg <= DOT_BITS'(uw_reg[0]) + DOT_BITS'(uw_reg[1]) + DOT_BITS'(uw_reg[2]);
        e3_reg <= DOT_BITS'(vw_reg[0]) + DOT_BITS'(vw_reg[1]) + DOT_BITS'(vw_reg[2]);

        for (int i = 0; i < 6; i++)
        begin
            phh_reg[i] <= (2*HB)'($signed(mx[i][DOT_BITS-1:HB]))
                        * (2*HB)'($signed(my[i][DOT_BITS-1:HB]));
            phl_reg[i] <= (2*HB+1)'($signed(mx[i][DOT_BITS-1:HB]))
                        * (2*HB+1)'($signed({1'b0, my[i][HB-1:0]}));
            plh_reg[i] <= (2*HB+1)'($signed({1'b0, mx[i][HB-1:0]}))
                        * (2*HB+1)'($signed(my[i][DOT_BITS-1:HB]));
            pll_reg[i] <= (2*HB)'(mx[i][HB-1:0]) * (2*HB)'(my[i][HB-1:0]);
        end
        a4_reg <= a3_reg;  b4_reg <= b3_reg;  c4_reg <= c3_reg;
        d4_reg <= d3_reg;  e4_reg <= e3_reg;

        ac_reg <= prod_next[0];
        bb_reg <= prod_next[1];
        be_reg <= prod_next[2];
        cd_reg <= prod_next[3];
        ae_reg <= prod_next[4];
        bd_reg <= prod_next[5];
        ap_reg <= a4_reg;  bp_reg <= b4_reg;  cp_reg <= c4_reg;
        dp_reg <= d4_reg;  ep_reg <= e4_reg;

        det_reg <= DET_BITS'(ac_reg) - DET_BITS'(bb_reg);
        sn0_reg <= DET_BITS'(be_reg) - DET_BITS'(cd_reg);
        tn0_reg <= DET_BITS'(ae_reg) - DET_BITS'(bd_reg);
        a5_reg <= ap_reg;  b5_reg <= bp_reg;  c5_reg <= cp_reg;
        d5_reg <= dp_reg;  e5_reg <= ep_reg;

        sn6_reg <= sn6_next;  sd6_reg <= sd6_next;
        tn6_reg <= tn6_next;  td6_reg <= td6_next;
        ndv_reg <= -DET_BITS'(d5_reg);
        bmd_reg <= DET_BITS'(b5_reg) - DET_BITS'(d5_reg);
        a6_reg  <= DET_BITS'(a5_reg);

        sn7_reg <= sn7_next;  sd7_reg <= sd7_next;
        tn7_reg <= tn7_next;  td7_reg <= td7_next;
    end

    // region of the unclamped solution
    always_comb
    begin
        if (det_reg[DET_BITS-1] || (det_reg == '0))
        begin
            sn6_next = '0;
            sd6_next = DET_BITS'(1);
            tn6_next = DET_BITS'(e5_reg);
            td6_next = DET_BITS'(c5_reg);
        end
        else if (sn0_reg[DET_BITS-1])
        begin
            sn6_next = '0;
            sd6_next = det_reg;
            tn6_next = DET_BITS'(e5_reg);
            td6_next = DET_BITS'(c5_reg);
        end
        else if (det_reg < sn0_reg)
        begin
            sn6_next = det_reg;
            sd6_next = det_reg;
            tn6_next = DET_BITS'(e5_reg) + DET_BITS'(b5_reg);
            td6_next = DET_BITS'(c5_reg);
        end
        else
        begin
            sn6_next = sn0_reg;
            sd6_next = det_reg;
            tn6_next = tn0_reg;
            td6_next = det_reg;
        end
    end

    // pin tc to an edge and recompute sc on it
    always_comb
    begin
        logic signed [DET_BITS-1:0] x;
        logic                       hit;
        sn7_next = sn6_reg;
        sd7_next = sd6_reg;
        tn7_next = tn6_reg;
        td7_next = td6_reg;
        x        = '0;
        hit      = 1'b0;
        if (tn6_reg[DET_BITS-1])
        begin
            tn7_next = '0;
            x        = ndv_reg;
            hit      = 1'b1;
        end
        else if (td6_reg < tn6_reg)
        begin
            tn7_next = td6_reg;
            x        = bmd_reg;
            hit      = 1'b1;
        end
        if (hit)
        begin
            if (x[DET_BITS-1])
            begin
                sn7_next = '0;
            end
            else if (a6_reg < x)
            begin
                sn7_next = sd6_reg;
            end
            else
            begin
                sn7_next = x;
                sd7_next = a6_reg;
            end
        end
    end

    ssd_div #(
        .NUM_BITS (DET_BITS)
    ) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_vld_reg[FRONT_LAT-1]),
        .num       (sn7_reg),
        .den       (sd7_reg),
        .out_valid (div_s_vld),
        .quot      (sc_q)
    );

    ssd_div #(
        .NUM_BITS (DET_BITS)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_vld_reg[FRONT_LAT-1]),
        .num       (tn7_reg),
        .den       (td7_reg),
        .out_valid (div_t_vld),
        .quot      (tc_q)
    );

    // hold u, v, w until the parameters are ready
    always_ff @(posedge clk)
    begin
        u_dly_reg[0] <= u_reg;
        v_dly_reg[0] <= v_reg;
        w_dly_reg[0] <= w_reg;
        for (int k = 1; k < UVW_DLY; k++)
        begin
            u_dly_reg[k] <= u_dly_reg[k-1];
            v_dly_reg[k] <= v_dly_reg[k-1];
            w_dly_reg[k] <= w_dly_reg[k-1];
        end
    end

    // distance vector and its squared length
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = (SQ_BITS'(qhh_reg[i]) <<< (2*PH))
                       + (SQ_BITS'(qhl_reg[i]) <<< (PH+1))
                       + SQ_BITS'(qll_reg[i]);
        end
        sum_next = SUM_BITS'($unsigned(sq_reg[0])) + SUM_BITS'($unsigned(sq_reg[1]))
                 + SUM_BITS'($unsigned(sq_reg[2]));
        y_ext    = Y_EXT'(sum_next[SUM_BITS-1:DIST_SHIFT]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            su_reg[i] <= P_BITS'($signed({1'b0, sc_q}))
                       * P_BITS'(u_dly_reg[UVW_DLY-1][i]);
            tv_reg[i] <= P_BITS'($signed({1'b0, tc_q}))
                       * P_BITS'(v_dly_reg[UVW_DLY-1][i]);
            ws_reg[i] <= P_BITS'(w_dly_reg[UVW_DLY-1][i]) <<< FRAC_BITS;
            p_reg[i]  <= ws_reg[i] + su_reg[i] - tv_reg[i];
            qhh_reg[i] <= (2*PU)'($signed(p_reg[i][P_BITS-1:PH]))
                        * (2*PU)'($signed(p_reg[i][P_BITS-1:PH]));
            qhl_reg[i] <= (PU+PH+1)'($signed(p_reg[i][P_BITS-1:PH]))
                        * (PU+PH+1)'($signed({1'b0, p_reg[i][PH-1:0]}));
            qll_reg[i] <= (2*PH)'(p_reg[i][PH-1:0]) * (2*PH)'(p_reg[i][PH-1:0]);
            sq_reg[i] <= sq_next[i];
        end
        sc1_reg <= sc_q;     tc1_reg <= tc_q;
        sc2_reg <= sc1_reg;  tc2_reg <= tc1_reg;
        sc3_reg <= sc2_reg;  tc3_reg <= tc2_reg;
        sc4_reg <= sc3_reg;  tc4_reg <= tc3_reg;
        sc5_reg <= sc4_reg;  tc5_reg <= tc4_reg;
        sat_reg <= |y_ext[Y_EXT-1:RAD_BITS];
        rad_reg <= y_ext[RAD_BITS-1:0];
    end

    ssd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (back_vld_reg[BACK_LAT-1]),
        .sat       (sat_reg),
        .rad       (rad_reg),
        .out_valid (root_vld),
        .root      (root)
    );

    always_ff @(posedge clk)
    begin
        sc_dly_reg[0] <= sc5_reg;
        tc_dly_reg[0] <= tc5_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            sc_dly_reg[k] <= sc_dly_reg[k-1];
            tc_dly_reg[k] <= tc_dly_reg[k-1];
        end
        result_reg.closest_distance <= root;
        result_reg.param_on_s       <= sc_dly_reg[SQRT_LAT-1];
        result_reg.param_on_k       <= tc_dly_reg[SQRT_LAT-1];
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SSD_ASSERT_DELAY(a_req_to_done, clk, rst_n, start && !busy, TOTAL_LAT, done, "request lost in pipeline")
    `SSD_ASSERT_IMPL(a_done_has_req, clk, rst_n, done, $past(start, TOTAL_LAT), "result without request")
    `SSD_ASSERT_IMPL(a_param_s_range, clk, rst_n, done, result.param_on_s <= ONE_Q16, "param_on_s above one")
    `SSD_ASSERT_IMPL(a_param_k_range, clk, rst_n, done, result.param_on_k <= ONE_Q16, "param_on_k above one")

endmodule

// ===== tb/ssd_distance_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_distance_checker
// Watches the request and result channels of the segment distance core,
// predicts each result from the accepted request and compares it field by
// field, in order, with the result that the core shows under done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_distance_checker
    import ssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  ssd_req_t    req,
    input  logic        done,
    input  ssd_result_t result,
    output int          fail_count,
    output int          pending
);

    typedef logic signed [191:0] big_t;

    ssd_result_t expected_results[$];

    function automatic big_t dot3(big_t p0, big_t p1, big_t p2, big_t q0, big_t q1, big_t q2);
        return p0 * q0 + p1 * q1 + p2 * q2;
    endfunction

    function automatic logic [FRAC_BITS:0] to_q16(big_t num, big_t den);
        big_t quo;
        if (num <= 0 || den <= 0)
        begin
            return '0;
        end
        if (num >= den)
        begin
            return ONE_Q16;
        end
        quo = (num <<< 16) / den;
        return quo[FRAC_BITS:0];
    endfunction

    function automatic ssd_result_t predict_closest(ssd_req_t q);
        big_t u[3];
        big_t v[3];
        big_t w[3];
        big_t a, b, c, d, e, det, sn, sd, tn, td, x;
        bit   hit;
        logic [FRAC_BITS:0] sc, tc;
        logic signed [63:0] p;
        logic [191:0] sum, y, cand, r;
        ssd_result_t res;
        u[0] = big_t'(q.s_end_x) - big_t'(q.s_start_x);
        u[1] = big_t'(q.s_end_y) - big_t'(q.s_start_y);
        u[2] = big_t'(q.s_end_z) - big_t'(q.s_start_z);
        v[0] = big_t'(q.k_end_x) - big_t'(q.k_start_x);
        v[1] = big_t'(q.k_end_y) - big_t'(q.k_start_y);
        v[2] = big_t'(q.k_end_z) - big_t'(q.k_start_z);
        w[0] = big_t'(q.s_start_x) - big_t'(q.k_start_x);
        w[1] = big_t'(q.s_start_y) - big_t'(q.k_start_y);
        w[2] = big_t'(q.s_start_z) - big_t'(q.k_start_z);
        a = dot3(u[0], u[1], u[2], u[0], u[1], u[2]);
        b = dot3(u[0], u[1], u[2], v[0], v[1], v[2]);
        c = dot3(v[0], v[1], v[2], v[0], v[1], v[2]);
        d = dot3(u[0], u[1], u[2], w[0], w[1], w[2]);
        e = dot3(v[0], v[1], v[2], w[0], w[1], w[2]);
        det = a * c - b * b;
        sd = det;
        td = det;
        if (det <= 0)
        begin
            sn = 0;
            sd = 1;
            tn = e;
            td = c;
        end
        else
        begin
            sn = b * e - c * d;
            tn = a * e - b * d;
            if (sn < 0)
            begin
                sn = 0;
                tn = e;
                td = c;
            end
            else if (sn > sd)
            begin
                sn = sd;
                tn = e + b;
                td = c;
            end
        end
        x = 0;
        hit = 1'b0;
        if (tn < 0)
        begin
            tn = 0;
            x = -d;
            hit = 1'b1;
        end
        else if (tn > td)
        begin
            tn = td;
            x = b - d;
            hit = 1'b1;
        end
        if (hit)
        begin
            if (x < 0)
            begin
                sn = 0;
            end
            else if (x > a)
            begin
                sn = sd;
            end
            else
            begin
                sn = x;
                sd = a;
            end
        end
        sc = to_q16(sn, sd);
        tc = to_q16(tn, td);
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = 64'(w[i]) * 65536 + 64'(sc) * 64'(u[i]) - 64'(tc) * 64'(v[i]);
            sum = sum + 192'(big_t'(p) * big_t'(p));
        end
        y = sum >> 32;
        r = 0;
        for (int bit_i = 62; bit_i >= 0; bit_i--)
        begin
            cand = r | (192'(1) << bit_i);
            if (cand * cand <= y)
            begin
                r = cand;
            end
        end
        res.closest_distance = (r > 192'(DIST_MAX)) ? DIST_MAX : r[DIST_BITS-1:0];
        res.param_on_s = sc;
        res.param_on_k = tc;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ssd_result_t exp_res;
        int          errs;
        if (!rst_n)
        begin
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (start && !busy)
            begin
                expected_results.push_back(predict_closest(req));
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errs++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.closest_distance !== result.closest_distance)
                    begin
                        $display("%0t: closest_distance expected %0d actual %0d", $time,
                                 exp_res.closest_distance, result.closest_distance);
                        errs++;
                    end
                    if (exp_res.param_on_s !== result.param_on_s)
                    begin
                        $display("%0t: param_on_s expected %0d actual %0d", $time,
                                 exp_res.param_on_s, result.param_on_s);
                        errs++;
                    end
                    if (exp_res.param_on_k !== result.param_on_k)
                    begin
                        $display("%0t: param_on_k expected %0d actual %0d", $time,
                                 exp_res.param_on_k, result.param_on_k);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for segment_segment_distance_core: directed corner requests,
// then random, small, parallel and degenerate segment pairs with random gaps.
// A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ssd_pkg::*;

    localparam int RANDOM_REQS = 1530;
    localparam int STALL_LIMIT = 4000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    ssd_req_t    req;
    logic        done;
    ssd_result_t result;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    int          req_index;
    bit          no_gaps;

    segment_segment_distance_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    ssd_distance_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("segment_segment_distance_core regression: fail");
                $finish;
            end
        end
    end

    task automatic send_request(ssd_req_t r);
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 31)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        req_index++;
    endtask

    function automatic coord_t rand_coord(int span);
        if (span == 0)
        begin
            return coord_t'($urandom);
        end
        return coord_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic ssd_req_t make_pair(coord_t sx0, coord_t sy0, coord_t sz0,
                                           coord_t sx1, coord_t sy1, coord_t sz1,
                                           coord_t kx0, coord_t ky0, coord_t kz0,
                                           coord_t kx1, coord_t ky1, coord_t kz1);
        ssd_req_t r;
        r = '{sx0, sy0, sz0, sx1, sy1, sz1, kx0, ky0, kz0, kx1, ky1, kz1};
        return r;
    endfunction

    function automatic ssd_req_t random_pair();
        ssd_req_t r;
        coord_t   dx, dy, dz;
        coord_t   mul;
        int       span;
        span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(4, 22));
        r = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span));
        case ($urandom_range(9))
            0, 1:
            begin
                // K parallel to S, scaled direction
                dx = r.s_end_x - r.s_start_x;
                dy = r.s_end_y - r.s_start_y;
                dz = r.s_end_z - r.s_start_z;
                mul = coord_t'($urandom_range(3));
                if ($urandom_range(1) == 1)
                begin
                    mul = -mul;
                end
                if (span == 0 || span > (1 << 20))
                begin
                    dx = dx >>> 3;
                    dy = dy >>> 3;
                    dz = dz >>> 3;
                    r.s_end_x = r.s_start_x + dx;
                    r.s_end_y = r.s_start_y + dy;
                    r.s_end_z = r.s_start_z + dz;
                end
                r.k_end_x = r.k_start_x + dx * mul;
                r.k_end_y = r.k_start_y + dy * mul;
                r.k_end_z = r.k_start_z + dz * mul;
            end
            2:
            begin
                r.s_end_x = r.s_start_x;
                r.s_end_y = r.s_start_y;
                r.s_end_z = r.s_start_z;
            end
            3:
            begin
                r.k_end_x = r.k_start_x;
                r.k_end_y = r.k_start_y;
                r.k_end_z = r.k_start_z;
            end
            4:
            begin
                r.k_start_x = r.s_end_x;
                r.k_start_y = r.s_end_y;
                r.k_start_z = r.s_end_z;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    initial
    begin
        coord_t lo, hi, z, one;
        lo  = {1'b1, {(COORD_BITS-1){1'b0}}};
        hi  = {1'b0, {(COORD_BITS-1){1'b1}}};
        z   = '0;
        one = coord_t'(256);
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        quiet_cycles = 0;
        req_index    = 0;
        no_gaps      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(make_pair(z, z, z, z, z, z, z, z, z, z, z, z));
        send_request(make_pair(lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo));
        send_request(make_pair(hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi));
        send_request(make_pair(lo, lo, lo, hi, hi, hi, hi, lo, hi, lo, hi, lo));
        send_request(make_pair(lo, lo, lo, lo, lo, lo, hi, hi, hi, hi, hi, hi));
        send_request(make_pair(lo, hi, lo, hi, lo, hi, lo, hi, lo, hi, lo, hi));
        send_request(make_pair(z, z, z, one, z, z, z, one, z, one, one, z));
        send_request(make_pair(z, z, z, one, z, z, z, -one, z, z, one, one));
        send_request(make_pair(z, z, z, one, z, z, z, one, z, one, one, z));
        send_request(make_pair(z, z, z, one, z, z, one + one, z, z,
                               coord_t'(3 * one), z, z));
        send_request(make_pair(z, z, z, one, z, z, -one, one, z,
                               coord_t'(-3 * one), one, z));
        send_request(make_pair(z, z, z, one, z, z, z, one, z, one, one, z));
        send_request(make_pair(z, z, z, coord_t'(4 * one), z, z,
                               coord_t'(2 * one), one, -one, coord_t'(2 * one), one, one));
        send_request(make_pair(z, z, z, coord_t'(4 * one), z, z,
                               coord_t'(6 * one), one, -one, coord_t'(6 * one), one, one));
        send_request(make_pair(z, z, z, coord_t'(4 * one), z, z,
                               coord_t'(-2 * one), one, -one, coord_t'(-2 * one), one, one));
        send_request(make_pair(z, z, z, coord_t'(4 * one), z, z,
                               coord_t'(2 * one), one, one, coord_t'(2 * one),
                               coord_t'(5 * one), coord_t'(9)));
        send_request(make_pair(one, one, one, one, one, one, z, z, z,
                               coord_t'(2 * one), z, z));
        send_request(make_pair(z, z, z, coord_t'(2 * one), z, z, one, one, one, one, one, one));
        send_request(make_pair(z, z, z, coord_t'(1), z, z, z, coord_t'(1), z, z, z,
                               coord_t'(1)));
        send_request(make_pair(lo, z, z, hi, z, z, z, lo, z, z, hi, z));

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            no_gaps = (n >= 500 && n < 800);
            send_request(random_pair());
        end
        start <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (TOTAL_LAT + 10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("segment_segment_distance_core regression: pass");
        end
        else
        begin
            $display("segment_segment_distance_core regression: fail");
        end
        $finish;
    end

endmodule
